### src/ultrasonic_echo_ranger_unit_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Concurrent check helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define UER_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uer assertion failed");
// next-cycle implication
`define UER_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uer assertion failed");
`else
`define UER_ASSERT_IMP(lbl, ante, cons)
`define UER_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, register indexes, status codes and timing constants.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int unsigned TICKS_PER_CM    = 58;
	localparam int unsigned TRIG_HIGH_TICKS = 10;
	localparam int unsigned TRIG_LOW_TICKS  = 4;
	localparam int unsigned CAP_MARGIN      = 2000;

	localparam int unsigned MAX_DIST_RESET  = 400;
	localparam int unsigned BLANKING_RESET  = 200;
	localparam int unsigned ECHO_WAIT_RESET = 8000;
	localparam int unsigned CAP_RESET       = MAX_DIST_RESET * TICKS_PER_CM + CAP_MARGIN;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DIST  = 2'd0,
		REG_BLANKING  = 2'd1,
		REG_ECHO_WAIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_STUCK_HIGH = 2'd1,
		ST_NO_ECHO    = 2'd2,
		ST_BEYOND_MAX = 2'd3
	} status_t;

	typedef struct packed {
		logic [9:0]  max_distance_cm;
		logic [9:0]  blanking_ticks;
		logic [15:0] echo_wait_ticks;
		logic [15:0] width_cap;
	} cfg_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} tick_t;

	typedef struct packed {
		logic       trigger_level;
		logic       busy_res;
		logic       done_res;
		status_t    status;
		logic [9:0] distance_cm;
	} result_t;

endpackage

### src/uer_chan_if.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface uer_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/uer_cfg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Holds the three registers and the derived echo width cap.
// ----------------------------------------------------------------------------
module uer_cfg
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t        cfg_q;
	logic [16:0] cap_raw;
	logic [15:0] cap_new;

	// cap = max * TICKS_PER_CM + margin, saturated to 16 bits
	assign cap_raw = {7'd0, cfg_data[9:0]} * 17'(TICKS_PER_CM) + 17'(CAP_MARGIN);
	assign cap_new = cap_raw[16] ? 16'hFFFF : cap_raw[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_distance_cm <= 10'(MAX_DIST_RESET);
			cfg_q.blanking_ticks  <= 10'(BLANKING_RESET);
			cfg_q.echo_wait_ticks <= 16'(ECHO_WAIT_RESET);
			cfg_q.width_cap       <= 16'(CAP_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_DIST: begin
					cfg_q.max_distance_cm <= cfg_data[9:0];
					cfg_q.width_cap       <= cap_new;
				end
				REG_BLANKING:  cfg_q.blanking_ticks  <= cfg_data[9:0];
				REG_ECHO_WAIT: cfg_q.echo_wait_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/uer_seq.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger sequencer
// Phase machine, tick and width counters, running quotient by TICKS_PER_CM.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_unit_macros.svh"

module uer_seq
	import uer_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  tick_t   tick_d,
	input  cfg_t    cfg,
	output result_t res_d
);

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_SETTLE  = 7'b0000010,
		PH_TLOW    = 7'b0000100,
		PH_THIGH   = 7'b0001000,
		PH_BLANK   = 7'b0010000,
		PH_RISE    = 7'b0100000,
		PH_MEASURE = 7'b1000000
	} phase_t;

	localparam int unsigned REM_W = $clog2(TICKS_PER_CM);

	phase_t           phase_q, phase_n, cur;
	logic [15:0]      ticks_q, ticks_n, ticks_c;
	logic [15:0]      width_q, width_n;
	logic [REM_W-1:0] rem_q, rem_n;
	logic [10:0]      cm_q, cm_n;
	logic             finish, pulse_over;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	always_comb begin
		phase_n    = phase_q;
		ticks_n    = ticks_q;
		width_n    = width_q;
		rem_n      = rem_q;
		cm_n       = cm_q;
		finish     = 1'b0;
		pulse_over = 1'b0;
		res_d      = '0;
		ticks_c    = ticks_q;

		unique case (phase_q) inside
			PH_SETTLE, PH_TLOW, PH_THIGH, PH_BLANK, PH_RISE, PH_MEASURE: cur = phase_q;
			default: cur = PH_IDLE;
		endcase

		// start from idle: the start tick is the first settle tick
		if (cur == PH_IDLE && tick_d.start_req) begin
			cur     = PH_SETTLE;
			ticks_c = '0;
			width_n = '0;
			rem_n   = '0;
			cm_n    = '0;
		end
		phase_n = cur;
		ticks_n = ticks_c;

		unique case (cur)
			PH_SETTLE: begin
				if (!tick_d.echo_level) begin
					phase_n = PH_TLOW;
					ticks_n = '0;
				end else begin
					ticks_n = sat_inc(ticks_c);
					if (ticks_n >= cfg.echo_wait_ticks) begin
						res_d.status = ST_STUCK_HIGH;
						finish       = 1'b1;
					end
				end
			end
			PH_TLOW: begin
				ticks_n = sat_inc(ticks_c);
				if (ticks_n >= 16'(TRIG_LOW_TICKS)) begin
					phase_n = PH_THIGH;
					ticks_n = '0;
				end
			end
			PH_THIGH: begin
				res_d.trigger_level = 1'b1;
				ticks_n = sat_inc(ticks_c);
				if (ticks_n >= 16'(TRIG_HIGH_TICKS)) begin
					ticks_n = '0;
					phase_n = (cfg.blanking_ticks == '0) ? PH_RISE : PH_BLANK;
				end
			end
			PH_BLANK: begin
				ticks_n = sat_inc(ticks_c);
				if (ticks_n >= {6'd0, cfg.blanking_ticks}) begin
					phase_n = PH_RISE;
					ticks_n = '0;
				end
			end
			PH_RISE: begin
				if (tick_d.echo_level) begin
					phase_n = PH_MEASURE;
					ticks_n = '0;
					width_n = '0;
					rem_n   = '0;
					cm_n    = '0;
				end else begin
					ticks_n = sat_inc(ticks_c);
					if (ticks_n >= cfg.echo_wait_ticks) begin
						res_d.status = ST_NO_ECHO;
						finish       = 1'b1;
					end
				end
			end
			PH_MEASURE: begin
				pulse_over = !tick_d.echo_level;
				if (tick_d.echo_level) begin
					// keep quotient and remainder of the width in step
					if (width_q != 16'hFFFF) begin
						width_n = width_q + 16'd1;
						if (rem_q == REM_W'(TICKS_PER_CM - 1)) begin
							rem_n = '0;
							cm_n  = cm_q + 11'd1;
						end else begin
							rem_n = rem_q + REM_W'(1);
						end
					end
					if (width_n >= cfg.width_cap) pulse_over = 1'b1;
				end
				if (pulse_over) begin
					finish = 1'b1;
					if (width_n == '0)
						res_d.status = ST_NO_ECHO;
					else if (cm_n > {1'b0, cfg.max_distance_cm})
						res_d.status = ST_BEYOND_MAX;
					else
						res_d.distance_cm = cm_n[9:0];
				end
			end
			default: ;
		endcase

		if (finish) begin
			res_d.done_res = 1'b1;
			phase_n        = PH_IDLE;
			ticks_n        = '0;
		end
		res_d.busy_res = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			width_q <= '0;
			rem_q   <= '0;
			cm_q    <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			ticks_q <= ticks_n;
			width_q <= width_n;
			rem_q   <= rem_n;
			cm_q    <= cm_n;
		end
	end

	`UER_ASSERT_NXT(a_done_to_idle, step && res_d.done_res, phase_q == PH_IDLE)
	`UER_ASSERT_IMP(a_status_needs_done, res_d.status != ST_OK, res_d.done_res)
	`UER_ASSERT_IMP(a_trig_in_high, res_d.trigger_level, phase_q == PH_THIGH)
	`UER_ASSERT_IMP(a_dist_only_ok, res_d.distance_cm != '0,
		res_d.done_res && res_d.status == ST_OK && phase_q == PH_MEASURE)

endmodule

### src/uer_out.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger result register
// Holds one result until taken; accepts a new one in the same cycle.
// ----------------------------------------------------------------------------
module uer_out
	import uer_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  result_t   res_d,
	output logic      can_load,
	uer_chan_if.source result
);

	logic    valid_s1;
	result_t res_s1;

	assign can_load = !valid_s1 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (result.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res_d;
		end
	end

	assign result.valid   = valid_s1;
	assign result.payload = res_s1;

endmodule

### src/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger unit
// Echo-pulse distance timer: one tick transaction in, one result out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    handshake
//  tick     in   start_req, echo_level                       valid/ready
//  result   out  trigger_level, busy_res, done_res,          valid/ready
//                status, distance_cm
//  cfg      in   cfg_index, cfg_data                         cfg_wr_en
//
//  Each tick transaction passes the sequencer combinationally; its result
//  appears in the result register on the next cycle. One tick per cycle while
//  no result stalls; the rate is set by the phase machine updating once
//  per accepted tick. arst_n puts the phase machine in idle and the registers
//  at their reset values; no clearing pass is needed.
//  A stalled result holds; the tick side keeps flowing while the result
//  register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	uer_chan_if.sink              tick,
	uer_chan_if.source            result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	tick_t   tick_d;
	result_t res_d;
	logic    can_load;
	logic    step;

	// a tick is taken whenever the result register can take its result
	assign tick.ready = can_load;
	assign step       = tick.valid && can_load;

	// repack the tick payload into the internal struct
	assign tick_d.start_req  = tick.payload.start_req;
	assign tick_d.echo_level = tick.payload.echo_level;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// phase machine: advance only on an accepted tick
	uer_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick_d (tick_d),
		.cfg    (cfg),
		.res_d  (res_d)
	);

	// result register: hold until the sink takes it
	uer_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res_d    (res_d),
		.can_load (can_load),
		.result   (result)
	);

endmodule
